// ===== rtl/mebt_pkg.sv =====
// Shared definitions for the Mandelbrot escape-time pixel block.
// Holds field widths, register indexes, multiplier request type and the colour stops.
// Depends on nothing; used by mebt_mac and mandelbrot_escape_time_pixel.
package mebt_pkg;

  localparam int COORD_BITS = 64;
  localparam int HALF_BITS  = COORD_BITS / 2;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int FRAC_BITS  = 58;
  localparam int STEP_BITS  = 63;
  localparam int PIX_BITS   = 12;
  localparam int DEPTH_BITS = 16;
  localparam int CSTEP_BITS = 24;
  localparam int CSTEP_FRAC = 16;
  localparam int CH_BITS    = 8;
  localparam int CFG_IDX_BITS = 3;

  // colour index before the modulo; shades per gradient segment (power of two)
  localparam int IDX_BITS   = DEPTH_BITS + CSTEP_BITS - CSTEP_FRAC;
  localparam int SHADE_BITS = 8;
  localparam int SHADES     = 1 << SHADE_BITS;
  localparam int QUO_BITS   = IDX_BITS - SHADE_BITS;
  localparam int MIX_BITS   = CH_BITS + SHADE_BITS + 1;

  // 2.0 and 4.0 in Q6.58
  localparam logic [COORD_BITS-1:0] PART_LIMIT = 64'h0800_0000_0000_0000;
  localparam logic [COORD_BITS-1:0] ESC_LIMIT  = 64'h1000_0000_0000_0000;

  localparam logic [DEPTH_BITS-1:0] LIMIT_RESET = 16'd8000;
  localparam logic [CSTEP_BITS-1:0] CSTEP_RESET = 24'd22938;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_LEFT     = 3'd0,
    REG_Y_START    = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_COLOR_STEP = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                  go;
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
  } mac_req_t;

  // three-stop gradient: stop seg, channel ch (0 red, 1 green, 2 blue)
  function automatic logic [CH_BITS-1:0] stop_channel(input logic [1:0] seg,
                                                       input logic [1:0] ch);
    logic [CH_BITS-1:0] v;
    case (seg)
      2'd0: begin
        case (ch)
          2'd0:    v = 8'd6;
          2'd1:    v = 8'd88;
          default: v = 8'd189;
        endcase
      end
      2'd1: begin
        case (ch)
          2'd0:    v = 8'd6;
          2'd1:    v = 8'd214;
          default: v = 8'd100;
        endcase
      end
      default: begin
        case (ch)
          2'd0:    v = 8'd255;
          2'd1:    v = 8'd99;
          default: v = 8'd133;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mebt_mac.sv =====
// Shared 64x64 unsigned multiplier: one 32x32 multiplier forms four partial products in turn.
// Result is the full 128-bit product; done pulses for one cycle when it is final.
// Depends on mebt_pkg.
module mebt_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  mebt_pkg::mac_req_t                  req,
  output logic [mebt_pkg::PROD_BITS-1:0]      prod,
  output logic                                done
);

  logic [mebt_pkg::COORD_BITS-1:0] op_a;
  logic [mebt_pkg::COORD_BITS-1:0] op_b;
  logic [1:0]                      cnt;
  logic [1:0]                      tag;
  logic                            active;
  logic                            pv;
  logic [mebt_pkg::COORD_BITS-1:0] part;
  logic [mebt_pkg::HALF_BITS-1:0]  mul_a;
  logic [mebt_pkg::HALF_BITS-1:0]  mul_b;
  logic [mebt_pkg::PROD_BITS-1:0]  part_ext;
  logic [mebt_pkg::PROD_BITS-1:0]  addend;

  // beat order: lo*lo, lo*hi, hi*lo, hi*hi
  assign mul_a = cnt[1] ? op_a[mebt_pkg::COORD_BITS-1:mebt_pkg::HALF_BITS]
                        : op_a[mebt_pkg::HALF_BITS-1:0];
  assign mul_b = cnt[0] ? op_b[mebt_pkg::COORD_BITS-1:mebt_pkg::HALF_BITS]
                        : op_b[mebt_pkg::HALF_BITS-1:0];

  always_comb begin
    part_ext = mebt_pkg::PROD_BITS'(part);
    case (tag) inside
      2'd0:       addend = part_ext;
      2'd1, 2'd2: addend = part_ext << mebt_pkg::HALF_BITS;
      default:    addend = part_ext << mebt_pkg::COORD_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pv     <= 1'b0;
      cnt    <= '0;
      tag    <= '0;
      done   <= 1'b0;
    end else begin
      done <= pv && (tag == 2'd3);
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
        pv     <= 1'b0;
      end else if (active) begin
        pv  <= 1'b1;
        tag <= cnt;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          active <= 1'b0;
        end
      end else begin
        pv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      op_a <= req.a;
      op_b <= req.b;
    end
    if (active) begin
      part <= mul_a * mul_b;
    end
    if (req.go) begin
      prod <= '0;
    end else if (pv) begin
      prod <= prod + addend;
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time pixel (uses mebt_pkg, mebt_mac): pixel in, depth and colour out.
// Per iteration: three 64x64 products on the one 32x32 multiplier, plus 3 steps.
// One pixel at a time, busy until the done beat; done is a one-cycle strobe, never stalled.
// Sync reset clears the sequencer and strobe and loads the register defaults.
module mandelbrot_escape_time_pixel (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel command
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mebt_pkg::PIX_BITS-1:0]         column,
  input  logic [mebt_pkg::PIX_BITS-1:0]         row,
  // result beat
  output logic                                  done,
  output logic [mebt_pkg::DEPTH_BITS-1:0]       depth,
  output logic                                  escaped,
  output logic [mebt_pkg::CH_BITS-1:0]          red,
  output logic [mebt_pkg::CH_BITS-1:0]          green,
  output logic [mebt_pkg::CH_BITS-1:0]          blue,
  // register writes
  input  logic                                  cfg_write,
  input  logic [mebt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mebt_pkg::COORD_BITS-1:0]       cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_CX    = 14'h0002,  // col * step_x in the multiplier
    S_CY    = 14'h0004,  // row * step_y
    S_CROSS = 14'h0008,  // |zx| * |zy|
    S_ADD   = 14'h0010,  // form the new z
    S_CHK   = 14'h0020,  // overflow and part-size test
    S_SQX   = 14'h0040,  // zx^2
    S_SQY   = 14'h0080,  // zy^2
    S_ESC   = 14'h0100,  // |z|^2 test and loop decision
    S_CLR   = 14'h0200,  // launch depth * color_step
    S_CMUL  = 14'h0400,
    S_SEG   = 14'h0800,  // gradient segment
    S_RGB   = 14'h1000,  // one channel per cycle
    S_FIN   = 14'h2000
  } state_t;

  localparam int CB = mebt_pkg::COORD_BITS;
  localparam int FB = mebt_pkg::FRAC_BITS;
  localparam int SB = mebt_pkg::SHADE_BITS;

  state_t state;
  state_t state_next;

  // configuration
  logic signed [CB-1:0]                    x_left;
  logic signed [CB-1:0]                    y_start;
  logic [mebt_pkg::STEP_BITS-1:0]          step_x;
  logic [mebt_pkg::STEP_BITS-1:0]          step_y;
  logic [mebt_pkg::DEPTH_BITS-1:0]         iteration_limit;
  logic [mebt_pkg::CSTEP_BITS-1:0]         color_step;

  // iteration datapath
  logic [mebt_pkg::PIX_BITS-1:0]           row_r;
  logic [CB-1:0]                           cx;
  logic [CB-1:0]                           cy;
  logic [CB-1:0]                           cross_xy;
  logic [CB-1:0]                           dxy;
  logic [CB-1:0]                           nx;
  logic [CB-1:0]                           ny;
  logic                                    ovf;
  logic [CB-1:0]                           mzx;
  logic [CB-1:0]                           mzy;
  logic                                    sgn_x;
  logic                                    sgn_y;
  logic [CB-1:0]                           sx;
  logic [CB-1:0]                           sy;
  logic [mebt_pkg::DEPTH_BITS-1:0]         iter;
  logic [mebt_pkg::DEPTH_BITS-1:0]         depth_r;
  logic                                    esc_r;

  // colour datapath
  logic [SB-1:0]                           k_r;
  logic [mebt_pkg::QUO_BITS-1:0]           q_r;
  logic [1:0]                              seg_r;
  logic [1:0]                              ch;
  logic [mebt_pkg::CH_BITS-1:0]            chan_r [3];

  // shared multiplier
  mebt_pkg::mac_req_t                      mac_req;
  logic [mebt_pkg::PROD_BITS-1:0]          mac_prod;
  logic                                    mac_done;

  // combinational helpers
  logic [CB-1:0]                           mx;
  logic [CB-1:0]                           my;
  logic                                    esc_part;
  logic [CB-1:0]                           sq_sum;
  logic                                    esc_sq;
  logic [mebt_pkg::DEPTH_BITS-1:0]         iter_next;
  logic                                    last;
  logic [CB-1:0]                           q_cross;
  logic                                    rem_cross;
  logic [CB-1:0]                           cross_val;
  logic [CB-1:0]                           nx_sum;
  logic [CB-1:0]                           ny_sum;
  logic                                    ovf_sum;
  logic [1:0]                              seg_nx;
  logic [mebt_pkg::CH_BITS-1:0]            stop_a;
  logic [mebt_pkg::CH_BITS-1:0]            stop_b;
  logic [SB:0]                             kc;
  logic [mebt_pkg::MIX_BITS-1:0]           mix;
  logic [mebt_pkg::CH_BITS-1:0]            chan_val;
  logic                                    accept;

  // q mod 3: weights of bits alternate 1, 2 since 2^i mod 3 does
  function automatic logic [1:0] mod3(input logic [mebt_pkg::QUO_BITS-1:0] q);
    logic [7:0] s;
    logic [3:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < mebt_pkg::QUO_BITS; i++) begin
      s = s + ((i % 2 == 1) ? {6'b0, q[i], 1'b0} : {7'b0, q[i]});
    end
    s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[7:6]);
    s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
    if (s3 >= 3'd6) begin
      s3 = s3 - 3'd6;
    end else if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

  mebt_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .prod (mac_prod),
    .done (mac_done)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // new z and its checks
  assign nx_sum  = dxy + cx;
  assign ny_sum  = cross_xy + cy;
  assign ovf_sum = ((~(dxy ^ cx)) & (dxy ^ nx_sum)) >> (CB - 1) != '0
                || ((~(cross_xy ^ cy)) & (cross_xy ^ ny_sum)) >> (CB - 1) != '0;
  assign mx       = nx[CB-1] ? (~nx + 64'd1) : nx;
  assign my       = ny[CB-1] ? (~ny + 64'd1) : ny;
  assign esc_part = ovf || (mx > mebt_pkg::PART_LIMIT) || (my > mebt_pkg::PART_LIMIT);

  assign sq_sum    = sx + sy;
  assign esc_sq    = sq_sum > mebt_pkg::ESC_LIMIT;
  assign iter_next = iter + 16'd1;
  assign last      = (iter_next == iteration_limit);

  // 2*zx*zy floored: product >> 57 with the sign applied toward minus infinity
  assign q_cross   = mac_prod[FB+CB-2:FB-1];
  assign rem_cross = |mac_prod[FB-2:0];
  assign cross_val = (sgn_x ^ sgn_y) ? (rem_cross ? ~q_cross : ~q_cross + 64'd1) : q_cross;

  // gradient blend for the current channel
  assign seg_nx   = (seg_r == 2'd2) ? 2'd0 : seg_r + 2'd1;
  assign stop_a   = mebt_pkg::stop_channel(seg_r, ch);
  assign stop_b   = mebt_pkg::stop_channel(seg_nx, ch);
  assign kc       = (SB + 1)'(mebt_pkg::SHADES) - {1'b0, k_r};
  assign mix      = mebt_pkg::MIX_BITS'(stop_a) * mebt_pkg::MIX_BITS'(kc)
                  + mebt_pkg::MIX_BITS'(stop_b) * mebt_pkg::MIX_BITS'(k_r);
  assign chan_val = mix[SB+mebt_pkg::CH_BITS-1:SB];

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mac_req    = '0;
    unique case (state)
      S_IDLE: begin
        mac_req.a = CB'(column);
        mac_req.b = CB'(step_x);
        if (start) begin
          mac_req.go = 1'b1;
          state_next = S_CX;
        end
      end
      S_CX: begin
        mac_req.a = CB'(row_r);
        mac_req.b = CB'(step_y);
        if (mac_done) begin
          mac_req.go = 1'b1;
          state_next = S_CY;
        end
      end
      S_CY: begin
        // z starts at zero, so the first cross product is of zeros
        if (mac_done) begin
          if (iteration_limit == '0) begin
            state_next = S_FIN;
          end else begin
            mac_req.go = 1'b1;
            state_next = S_CROSS;
          end
        end
      end
      S_CROSS: begin
        if (mac_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: state_next = S_CHK;
      S_CHK: begin
        mac_req.a = mx;
        mac_req.b = mx;
        if (esc_part) begin
          state_next = S_CLR;
        end else begin
          mac_req.go = 1'b1;
          state_next = S_SQX;
        end
      end
      S_SQX: begin
        mac_req.a = mzy;
        mac_req.b = mzy;
        if (mac_done) begin
          mac_req.go = 1'b1;
          state_next = S_SQY;
        end
      end
      S_SQY: begin
        if (mac_done) begin
          state_next = S_ESC;
        end
      end
      S_ESC: begin
        mac_req.a = mzx;
        mac_req.b = mzy;
        if (esc_sq) begin
          state_next = S_CLR;
        end else if (last) begin
          state_next = S_FIN;
        end else begin
          mac_req.go = 1'b1;
          state_next = S_CROSS;
        end
      end
      S_CLR: begin
        mac_req.a  = CB'(depth_r);
        mac_req.b  = CB'(color_step);
        mac_req.go = 1'b1;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        if (mac_done) begin
          state_next = S_SEG;
        end
      end
      S_SEG: state_next = S_RGB;
      S_RGB: begin
        if (ch == 2'd2) begin
          state_next = S_FIN;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // register file; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      x_left          <= '0;
      y_start         <= '0;
      step_x          <= '0;
      step_y          <= '0;
      iteration_limit <= mebt_pkg::LIMIT_RESET;
      color_step      <= mebt_pkg::CSTEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mebt_pkg::REG_X_LEFT:     x_left          <= cfg_data;
        mebt_pkg::REG_Y_START:    y_start         <= cfg_data;
        mebt_pkg::REG_STEP_X:     step_x          <= cfg_data[mebt_pkg::STEP_BITS-1:0];
        mebt_pkg::REG_STEP_Y:     step_y          <= cfg_data[mebt_pkg::STEP_BITS-1:0];
        mebt_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[mebt_pkg::DEPTH_BITS-1:0];
        mebt_pkg::REG_COLOR_STEP: color_step      <= cfg_data[mebt_pkg::CSTEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // datapath, advanced by the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          row_r <= row;
        end
      end
      S_CX: begin
        if (mac_done) begin
          cx <= x_left + mac_prod[CB-1:0];  // wraps mod 2^64
        end
      end
      S_CY: begin
        if (mac_done) begin
          cy      <= y_start + mac_prod[CB-1:0];
          sx      <= '0;
          sy      <= '0;
          sgn_x   <= 1'b0;
          sgn_y   <= 1'b0;
          iter    <= '0;
          depth_r <= iteration_limit;
          esc_r   <= 1'b0;
        end
      end
      S_CROSS: begin
        if (mac_done) begin
          cross_xy <= cross_val;
          dxy      <= sx - sy;
        end
      end
      S_ADD: begin
        nx  <= nx_sum;
        ny  <= ny_sum;
        ovf <= ovf_sum;
      end
      S_CHK: begin
        mzx   <= mx;
        mzy   <= my;
        sgn_x <= nx[CB-1];
        sgn_y <= ny[CB-1];
        if (esc_part) begin
          depth_r <= iter;
          esc_r   <= 1'b1;
        end
      end
      S_SQX: begin
        if (mac_done) begin
          sx <= mac_prod[FB+CB-1:FB];
        end
      end
      S_SQY: begin
        if (mac_done) begin
          sy <= mac_prod[FB+CB-1:FB];
        end
      end
      S_ESC: begin
        if (esc_sq) begin
          depth_r <= iter;
          esc_r   <= 1'b1;
        end else if (last) begin
          depth_r <= iteration_limit;
          esc_r   <= 1'b0;
        end else begin
          iter <= iter_next;
        end
      end
      S_CMUL: begin
        if (mac_done) begin
          k_r <= mac_prod[mebt_pkg::CSTEP_FRAC+SB-1:mebt_pkg::CSTEP_FRAC];
          q_r <= mac_prod[mebt_pkg::CSTEP_FRAC+mebt_pkg::IDX_BITS-1:mebt_pkg::CSTEP_FRAC+SB];
        end
      end
      S_SEG: begin
        seg_r <= mod3(q_r);
        ch    <= 2'd0;
      end
      S_RGB: begin
        chan_r[ch] <= chan_val;
        ch         <= ch + 2'd1;
      end
      default: ;
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      depth   <= depth_r;
      escaped <= esc_r;
      red     <= esc_r ? chan_r[0] : '0;
      green   <= esc_r ? chan_r[1] : '0;
      blue    <= esc_r ? chan_r[2] : '0;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not raise busy");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && !escaped) |-> (red == '0 && green == '0 && blue == '0))
    else $error("pixel that did not escape is not black");

  a_mac_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_CX || state == S_CY || state == S_CROSS || state == S_SQX
                  || state == S_SQY || state == S_CMUL))
    else $error("multiplier finished outside a waiting state");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the Mandelbrot escape-time pixel block.
// Holds its own fixed-point predictor and the result checker; needs only mebt_pkg and the block.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 4;    // quiet cycles before a register write
  localparam int TAIL_CYCLES     = 64;   // look for stray beats once all are in
  // sized well above the slowest pixel expected here: limit 200, no escape
  localparam int WATCHDOG_CYCLES = 60000;

  localparam int GRAD_SHADES = 256;
  localparam int INDEX_SPAN  = 3 * GRAD_SHADES;

  // 2.0 and 4.0 in Q6.58
  localparam logic [63:0] Q_TWO  = 64'h0800_0000_0000_0000;
  localparam logic [63:0] Q_FOUR = 64'h1000_0000_0000_0000;

  // register indexes the block does not decode
  localparam logic [mebt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [mebt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  // view over the set: real -2.2 .. 0.8, imaginary -1.5 .. 1.5 across 4096 pixels
  localparam logic [63:0] VIEW_LEFT = 64'hF733_3333_3333_3333;
  localparam logic [63:0] VIEW_TOP  = 64'hFA00_0000_0000_0000;
  localparam logic [63:0] VIEW_STEP = 64'h0000_C000_0000_0000;

  typedef struct packed {
    logic [mebt_pkg::DEPTH_BITS-1:0] depth;
    logic                            escaped;
    logic [mebt_pkg::CH_BITS-1:0]    red;
    logic [mebt_pkg::CH_BITS-1:0]    green;
    logic [mebt_pkg::CH_BITS-1:0]    blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [mebt_pkg::PIX_BITS-1:0]     column;
  logic [mebt_pkg::PIX_BITS-1:0]     row;
  logic                              done;
  logic [mebt_pkg::DEPTH_BITS-1:0]   depth;
  logic                              escaped;
  logic [mebt_pkg::CH_BITS-1:0]      red;
  logic [mebt_pkg::CH_BITS-1:0]      green;
  logic [mebt_pkg::CH_BITS-1:0]      blue;
  logic                              cfg_write;
  logic [mebt_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [mebt_pkg::COORD_BITS-1:0]   cfg_data;

  mandelbrot_escape_time_pixel dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .column    (column),
    .row       (row),
    .done      (done),
    .depth     (depth),
    .escaped   (escaped),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor's copy of the register file
  logic [63:0] reg_x_left;
  logic [63:0] reg_y_start;
  logic [62:0] reg_step_x;
  logic [62:0] reg_step_y;
  logic [15:0] reg_iter_limit;
  logic [23:0] reg_colour_step;

  // gradient stops, three channels each (red, green, blue)
  int grad_stop [0:8] = '{6, 88, 189, 6, 214, 100, 255, 99, 133};

  pixel_t pending_pixels [$];   // expected result beats, oldest first

  int sender_idle_pct;
  int fail_count;
  int pixels_sent;
  int reg_writes;
  int escaped_seen;
  int inside_seen;
  int deepest_escape;
  int quiet_cycles;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] mag_q(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // floor(v*v / 2^58); only called for |v| <= 2.0
  function automatic logic [63:0] square_q(input logic [63:0] v);
    logic [127:0] prod;
    prod = {64'd0, mag_q(v)} * {64'd0, mag_q(v)};
    return prod[121:58];
  endfunction

  function automatic pixel_t predict_pixel(input logic [11:0] col, input logic [11:0] rw);
    pixel_t      res;
    logic [63:0] cx, cy, zx, zy, sx, sy, nx, ny, diff, cross_term;
    logic [127:0] prod;
    logic [39:0] scaled;
    logic        ov, esc, frac_left;
    int          idx, seg, k, a, b;
    int          rgb [0:2];
    res = '0;
    // origin plus index times step, wrapping modulo 2^64
    cx = reg_x_left + col * reg_step_x;
    cy = reg_y_start + rw * reg_step_y;
    zx = '0; zy = '0; sx = '0; sy = '0;
    esc = 1'b0;
    res.depth = reg_iter_limit;
    for (int d = 0; d < reg_iter_limit && !esc; d++) begin
      // 2*zx*zy: exact product >> 57, floored toward minus infinity
      prod = {64'd0, mag_q(zx)} * {64'd0, mag_q(zy)};
      cross_term = prod[120:57];
      frac_left  = |prod[56:0];
      if ((zx[63] ^ zy[63]) && (cross_term != '0 || frac_left))
        cross_term = -(cross_term + {63'd0, frac_left});
      diff = sx - sy;
      nx = diff + cx;
      ny = cross_term + cy;
      ov = (~(diff[63] ^ cx[63]) & (diff[63] ^ nx[63])) |
           (~(cross_term[63] ^ cy[63]) & (cross_term[63] ^ ny[63]));
      // a part beyond 2.0 or a wrapped sum escapes at once
      if (ov || mag_q(nx) > Q_TWO || mag_q(ny) > Q_TWO) begin
        esc = 1'b1;
      end else begin
        sx = square_q(nx);
        sy = square_q(ny);
        if (sx + sy > Q_FOUR) esc = 1'b1;
      end
      zx = nx;
      zy = ny;
      if (esc) res.depth = d[15:0];
    end
    res.escaped = esc;
    // escaped pixels take a gradient colour; the rest stay black
    if (esc) begin
      scaled = res.depth * reg_colour_step;
      idx = int'(scaled[39:16]) % INDEX_SPAN;
      seg = idx / GRAD_SHADES;
      k   = idx % GRAD_SHADES;
      for (int ch = 0; ch < 3; ch++) begin
        a = grad_stop[seg * 3 + ch];
        b = grad_stop[((seg + 1) % 3) * 3 + ch];
        rgb[ch] = (a * (GRAD_SHADES - k) + b * k) / GRAD_SHADES;
      end
      res.red   = rgb[0][7:0];
      res.green = rgb[1][7:0];
      res.blue  = rgb[2][7:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: one beat per done strobe, sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pixel_t got;
    pixel_t exp_px;
    logic   bad;
    if (!rst && done) begin
      got = {depth, escaped, red, green, blue};
      if (pending_pixels.size() == 0) begin
        $error("result beat with nothing outstanding: depth %0d escaped %0b", depth, escaped);
        fail_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        bad = 1'b0;
        if (got.depth !== exp_px.depth) begin
          $error("depth: expected %0d, got %0d", exp_px.depth, got.depth);
          bad = 1'b1;
        end
        if (got.escaped !== exp_px.escaped) begin
          $error("escaped: expected %0b, got %0b", exp_px.escaped, got.escaped);
          bad = 1'b1;
        end
        if (got.red !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, got.red);
          bad = 1'b1;
        end
        if (got.green !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, got.green);
          bad = 1'b1;
        end
        if (got.blue !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, got.blue);
          bad = 1'b1;
        end
        if (bad) fail_count++;
        if (exp_px.escaped) begin
          escaped_seen++;
          if (int'(exp_px.depth) > deepest_escape) deepest_escape = int'(exp_px.depth);
        end else begin
          inside_seen++;
        end
      end
    end
  end

  // Watchdog: too long with neither a command nor a result beat means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no beat for %0d cycles, %0d outstanding",
                 quiet_cycles, pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Block is idle once every outstanding beat is back
  task automatic wait_idle();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mebt_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] val);
    wait_idle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = {$urandom, $urandom};
    case (idx)
      mebt_pkg::REG_X_LEFT:     reg_x_left      = val;
      mebt_pkg::REG_Y_START:    reg_y_start     = val;
      mebt_pkg::REG_STEP_X:     reg_step_x      = val[62:0];
      mebt_pkg::REG_STEP_Y:     reg_step_y      = val[62:0];
      mebt_pkg::REG_ITER_LIMIT: reg_iter_limit  = val[15:0];
      mebt_pkg::REG_COLOR_STEP: reg_colour_step = val[23:0];
      default: ;  // undecoded index: nothing changes
    endcase
    reg_writes++;
  endtask

  // One pixel command; random gaps before it carry noise on the pixel fields
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      column = 12'($urandom);
      row    = 12'($urandom);
      @(negedge clk);
    end
    start  = 1'b1;
    column = col;
    row    = rw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(predict_pixel(col, rw));
    pixels_sent++;
    @(negedge clk);
    start  = 1'b0;
    column = 12'($urandom);
    row    = 12'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of limit, colour step and origin, with only the column step set
  task automatic test_reset_defaults();
    write_reg(mebt_pkg::REG_STEP_X, 64'h0100_0000_0000_0000);   // 0.25
    send_pixel(12'd2, 12'd0);      // c = 0.5
    send_pixel(12'd3, 12'd4095);   // c = 0.75, row step still zero
  endtask

  // Zero, one and full-scale iteration limits
  task automatic test_limit_edges();
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'd0);
    send_pixel(12'd2, 12'd0);      // no iteration at all
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'd1);
    send_pixel(12'd0, 12'd0);      // c = 0 runs out after one
    send_pixel(12'd12, 12'd0);     // c = 3 escapes at once
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd2, 12'd4095);
    send_pixel(12'd13, 12'd4095);
  endtask

  // Points sitting exactly on |part| = 2.0, plus one past it and one inside
  task automatic test_escape_boundaries();
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'd40);
    write_reg(mebt_pkg::REG_X_LEFT, 64'hF800_0000_0000_0000);   // -2.0
    write_reg(mebt_pkg::REG_STEP_X, 64'h0200_0000_0000_0000);   // 0.5
    write_reg(mebt_pkg::REG_Y_START, 64'd0);
    write_reg(mebt_pkg::REG_STEP_Y, 64'h0200_0000_0000_0000);
    send_pixel(12'd0, 12'd0);      // -2.0 stays put: inside
    send_pixel(12'd8, 12'd0);      // +2.0 equals the bound, escapes one later
    send_pixel(12'd9, 12'd0);      // 2.5
    send_pixel(12'd4, 12'd4);      // 2.0i
    send_pixel(12'd3, 12'd1);      // -0.5+0.5i, inside the cardioid
  endtask

  // Origins and steps at full scale so c wraps round
  task automatic test_coordinate_wrap();
    write_reg(mebt_pkg::REG_X_LEFT, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(mebt_pkg::REG_Y_START, 64'h8000_0000_0000_0000);
    write_reg(mebt_pkg::REG_STEP_X, 64'hFFFF_FFFF_FFFF_FFFF);   // top bit dropped
    write_reg(mebt_pkg::REG_STEP_Y, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);      // wraps to a point a hair from zero
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
  endtask

  // Undecoded register writes, then colour step extremes along the real axis just past 0.25
  task automatic test_colour_extremes();
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'd200);
    write_reg(mebt_pkg::REG_X_LEFT, 64'h0100_0000_0000_0000);   // 0.25
    write_reg(mebt_pkg::REG_STEP_X, 64'h0001_0000_0000_0000);   // 1/1024
    write_reg(mebt_pkg::REG_Y_START, 64'd0);
    write_reg(mebt_pkg::REG_STEP_Y, 64'd0);
    write_reg(mebt_pkg::REG_COLOR_STEP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd3, 12'd0);
    send_pixel(12'd5, 12'd0);
    send_pixel(12'd9, 12'd0);
    send_pixel(12'd17, 12'd0);
    send_pixel(12'd64, 12'd0);
    write_reg(mebt_pkg::REG_COLOR_STEP, 64'd1);
    send_pixel(12'd3, 12'd0);
  endtask

  // Random pixels: mostly over a view of the set, then a burst under wild registers
  task automatic test_random_pixels(input int idle_pct, input int n_view, input int n_wild);
    logic [15:0] lim;
    sender_idle_pct = idle_pct;
    write_reg(mebt_pkg::REG_X_LEFT, {VIEW_LEFT[63:32], VIEW_LEFT[31:0] ^ $urandom});
    write_reg(mebt_pkg::REG_Y_START, {VIEW_TOP[63:32], VIEW_TOP[31:0] ^ $urandom});
    write_reg(mebt_pkg::REG_STEP_X, VIEW_STEP + $urandom_range(0, 32'hFFFF_FFFF));
    write_reg(mebt_pkg::REG_STEP_Y, VIEW_STEP + $urandom_range(0, 32'hFFFF_FFFF));
    write_reg(mebt_pkg::REG_ITER_LIMIT, 64'($urandom_range(8, 120)));
    write_reg(mebt_pkg::REG_COLOR_STEP, 64'($urandom_range(1, 24'hFF_FFFF)));
    repeat (n_view) send_pixel(12'($urandom), 12'($urandom));
    // wild registers: upper data bits random too, limit kept short
    lim = 16'($urandom_range(1, 200));
    write_reg(mebt_pkg::REG_X_LEFT, {$urandom, $urandom});
    write_reg(mebt_pkg::REG_Y_START, {$urandom, $urandom});
    write_reg(mebt_pkg::REG_STEP_X, {$urandom, $urandom});
    write_reg(mebt_pkg::REG_STEP_Y, {$urandom, $urandom});
    write_reg(mebt_pkg::REG_ITER_LIMIT, {$urandom, 16'($urandom), lim});
    write_reg(mebt_pkg::REG_COLOR_STEP, {$urandom, $urandom});
    repeat (n_wild) send_pixel(12'($urandom), 12'($urandom));
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    column    = '0;
    row       = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sender_idle_pct = 13;
    fail_count      = 0;
    pixels_sent     = 0;
    reg_writes      = 0;
    escaped_seen    = 0;
    inside_seen     = 0;
    deepest_escape  = 0;
    quiet_cycles    = 0;
    reg_x_left      = '0;
    reg_y_start     = '0;
    reg_step_x      = '0;
    reg_step_y      = '0;
    reg_iter_limit  = 16'd8000;
    reg_colour_step = 24'd22938;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_limit_edges();
    test_escape_boundaries();
    test_coordinate_wrap();
    test_colour_extremes();
    test_random_pixels(13, 20, 5);
    test_random_pixels(81, 20, 5);
    test_random_pixels(0, 20, 5);

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Evaluated %0d pixels (%0d escaped, deepest at %0d; %0d inside) over %0d writes.",
             pixels_sent, escaped_seen, deepest_escape, inside_seen, reg_writes);
    $display("Sender gaps at 13, 81 and 0 per cent; %0d beats mismatched.", fail_count);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
